@@ design/mpo_pkg.sv @@
`default_nettype none
package mpo_pkg;

   // number of detuned voices used by the quad modes, 1 to 3
   localparam int DetunedVoices = 3;

   localparam int PhaseWidth  = 24;
   localparam int VoiceWidth  = 16;
   localparam int SampleWidth = 8;
   localparam int ShapeWidth  = 7;
   localparam int ModeWidth   = 3;

   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 16;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 24;

   typedef enum logic [ModeWidth-1:0] {
      MODE_MANGLE_SAW = 3'd0,
      MODE_FOLD_TRI   = 3'd1,
      MODE_HARD_PWM   = 3'd2,
      MODE_QUAD_SAW   = 3'd3,
      MODE_QUAD_PWM   = 3'd4
   } mode_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_WAVEFORM_MODE   = 2'd0,
      CSR_SHAPE_AMOUNT    = 2'd1,
      CSR_PHASE_INCREMENT = 2'd2
   } csr_index_type;

   localparam logic [SampleWidth-1:0] SampleMid   = 8'd128;
   localparam logic [SampleWidth-1:0] SampleFull  = 8'd255;
   localparam logic [SampleWidth-1:0] PwmBase     = 8'd127;
   localparam logic [SampleWidth-1:0] PwmStep     = 8'd63;
   localparam int                     SpreadShift = 13;
   localparam int                     SawShift    = 10;
   localparam int                     FoldShift   = 7;

endpackage
`default_nettype wire

@@ design/multimode_phase_oscillator.sv @@
// multimode phase oscillator: one 8-bit sample per accepted request
// the response is registered at the edge that accepts the request
// throughput: 1 request per cycle while responses are taken; the single output register is refilled
//   while its response is taken, so back-to-back requests stream at full rate
// reset (synchronous, active high): phases, configuration and response valid clear
`default_nettype none
module multimode_phase_oscillator
   import mpo_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   // configuration write port
   input  wire                     csr_we,
   input  wire [CsrAddrWidth-1:0]  csr_addr,
   input  wire [CsrDataWidth-1:0]  csr_wdata,
   // request channel
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire [ReqDataWidth-1:0]  req_tdata,   // [0] sync_in, [7:1] zero
   // response channel
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata    // [7:0] sample_out, [8] sync_out, [15:9] zero
);

   // configuration registers
   mode_type                   mode_ff;
   logic [ShapeWidth-1:0]      shape_ff;
   logic [PhaseWidth-1:0]      inc_ff;

   // oscillator state
   logic [PhaseWidth-1:0]      phase_ff, phase_in;
   logic [VoiceWidth-1:0]      voice_ff [DetunedVoices];
   logic [VoiceWidth-1:0]      voice_in [DetunedVoices];

   // response register
   logic                       rsp_valid_ff;
   logic [SampleWidth-1:0]     sample_ff, sample_in;
   logic                       sync_ff, sync_in;

   logic                       accept;
   logic [PhaseWidth:0]        phase_sum;
   logic [VoiceWidth-1:0]      p_int;
   logic [VoiceWidth-1:0]      inc_int;
   logic [VoiceWidth+ShapeWidth-1:0] detune_prod;
   logic [VoiceWidth-1:0]      spread;
   logic [VoiceWidth-1:0]      step;
   logic                       quad_mode;
   logic [SampleWidth-1:0]     fold_t, fold_v;
   logic [SampleWidth-1:0]     shape8;
   logic [SampleWidth-1:0]     pwm_level;
   logic [VoiceWidth-1:0]      pwm_thr;
   logic [SampleWidth-1:0]     mix;

   // output register frees up in the same cycle it is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-SampleWidth-1){1'b0}}, sync_ff, sample_ff};

   always_comb begin
      // main phase: optional sync clear, then the increment
      phase_sum = {1'b0, (req_tdata[0] ? {PhaseWidth{1'b0}} : phase_ff)} +
                  {1'b0, inc_ff};
      phase_in  = phase_sum[PhaseWidth-1:0];
      sync_in   = phase_sum[PhaseWidth];
      p_int     = phase_in[PhaseWidth-1 -: VoiceWidth];
      inc_int   = inc_ff[PhaseWidth-1 -: VoiceWidth];
      shape8    = {1'b0, shape_ff};

      // detune spread from the integer increment
      detune_prod = inc_int * shape_ff;
      spread      = VoiceWidth'(detune_prod >> SpreadShift) + 1'b1;
      quad_mode   = (mode_ff == MODE_QUAD_SAW) || (mode_ff == MODE_QUAD_PWM);

      // voice i steps by inc + (i + 1) * spread, chained
      step = inc_int;
      for (int i = 0; i < DetunedVoices; i++) begin
         step        = step + spread;
         voice_in[i] = quad_mode ? (voice_ff[i] + step) : voice_ff[i];
      end

      // folded triangle
      fold_t = p_int[FoldShift +: SampleWidth];
      fold_v = p_int[VoiceWidth-1] ? fold_t : ~fold_t;
      if (fold_v < shape8) begin
         fold_v = {shape_ff, 1'b0} - fold_v;
      end

      // pulse threshold shared by the pwm modes
      pwm_level = PwmBase + shape8;
      pwm_thr   = {pwm_level, {(VoiceWidth-SampleWidth){1'b0}}};

      mix = '0;
      case (mode_ff)
         MODE_QUAD_SAW: begin
            mix = SampleWidth'(p_int >> SawShift);
            for (int i = 0; i < DetunedVoices; i++) begin
               mix = mix + SampleWidth'(voice_in[i] >> SawShift);
            end
         end
         MODE_QUAD_PWM: begin
            mix = (p_int < pwm_thr) ? '0 : PwmStep;
            for (int i = 0; i < DetunedVoices; i++) begin
               mix = mix + ((voice_in[i] < pwm_thr) ? '0 : PwmStep);
            end
         end
         default: begin
            mix = '0;
         end
      endcase

      case (mode_ff)
         MODE_MANGLE_SAW: begin
            sample_in = ((p_int[VoiceWidth-1 -: SampleWidth] ^ {shape_ff, 1'b0}) & ~shape8)
                        + (shape8 >> 1);
         end
         MODE_FOLD_TRI: begin
            sample_in = fold_v;
         end
         MODE_HARD_PWM: begin
            sample_in = (p_int[VoiceWidth-1 -: SampleWidth] < pwm_level) ? '0 : SampleFull;
         end
         MODE_QUAD_SAW, MODE_QUAD_PWM: begin
            sample_in = mix;
         end
         default: begin
            // unused mode codes sit at midscale
            sample_in = SampleMid;
         end
      endcase
   end

   // configuration writes, an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MANGLE_SAW;
         shape_ff <= '0;
         inc_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WAVEFORM_MODE:   mode_ff  <= mode_type'(csr_wdata[ModeWidth-1:0]);
            CSR_SHAPE_AMOUNT:    shape_ff <= csr_wdata[ShapeWidth-1:0];
            CSR_PHASE_INCREMENT: inc_ff   <= csr_wdata[PhaseWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // phase state advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         for (int i = 0; i < DetunedVoices; i++) begin
            voice_ff[i] <= '0;
         end
      end else if (accept) begin
         phase_ff <= phase_in;
         for (int i = 0; i < DetunedVoices; i++) begin
            voice_ff[i] <= voice_in[i];
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= sample_in;
         sync_ff   <= sync_in;
      end
   end

endmodule
`default_nettype wire

@@ design/mpo_checker.sv @@
`default_nettype none
module mpo_checker
   import mpo_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tvalid,
   input wire                    req_tready,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready,
   input wire [RspDataWidth-1:0] rsp_tdata
);

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // every accepted request shows a response in the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted request gave no response");

   // a stalled response blocks new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");

   // stalled response holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // padding above sync_out stays zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RspDataWidth-1:SampleWidth+1] == '0))
      else $error("response padding not zero");

endmodule

bind multimode_phase_oscillator mpo_checker u_mpo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import mpo_pkg::*;

   // run limits
   localparam int CycleLimit   = 400000;
   localparam int RandomItems  = 1560;
   localparam int HoldCycles   = 300;
   localparam int ReportLimit  = 10;

   // mode codes with no waveshaper behind them
   localparam logic [ModeWidth-1:0] ModeSpareLow  = 3'd5;
   localparam logic [ModeWidth-1:0] ModeSpareMid  = 3'd6;
   localparam logic [ModeWidth-1:0] ModeSpareHigh = 3'd7;

   localparam logic [PhaseWidth-1:0] IncrementMax = 24'hFFFFFF;
   localparam logic [ShapeWidth-1:0] ShapeMax     = 7'd127;

   // one expected response: sample and the phase carry
   typedef struct packed {
      logic [SampleWidth-1:0] sample;
      logic                   sync_out;
   } osc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    csr_we    = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr  = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata  = '0;   // [0] sync_in, [7:1] zero

   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;         // [7:0] sample_out, [8] sync_out, [15:9] zero

   multimode_phase_oscillator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // oscillator shadow: configuration and phases as the block should hold them
   logic [ModeWidth-1:0]  cfg_mode      = '0;
   logic [ShapeWidth-1:0] cfg_shape     = '0;
   logic [PhaseWidth-1:0] cfg_increment = '0;
   logic [PhaseWidth-1:0] main_phase    = '0;
   logic [VoiceWidth-1:0] voice_phase [3] = '{default: '0};

   osc_result_type expected_samples [$];

   int error_count   = 0;
   int cycle_count   = 0;
   int items_sent    = 0;
   int burst_left    = 0;

   // receiver hold-off request, raised by a test and taken by the receiver
   bit hold_request  = 1'b0;
   int hold_left     = 0;
   int stall_style   = 0;
   int stall_left    = 0;
   int stall_tick    = 0;

   // advance the shadow by one sample and return what the block should send
   function automatic osc_result_type predict_response(input logic sync_in);
      logic [PhaseWidth:0]    sum;
      logic [VoiceWidth-1:0]  p;
      logic [VoiceWidth-1:0]  inc_int;
      logic [VoiceWidth-1:0]  spread;
      logic [VoiceWidth-1:0]  step;
      logic [VoiceWidth-1:0]  thr;
      logic [22:0]            prod;
      logic [SampleWidth-1:0] t;
      logic [SampleWidth-1:0] v;
      logic [SampleWidth-1:0] acc;
      osc_result_type         r;
      int                     i;

      if (sync_in) main_phase = '0;
      sum        = {1'b0, main_phase} + {1'b0, cfg_increment};
      r.sync_out = sum[PhaseWidth];
      main_phase = sum[PhaseWidth-1:0];

      p       = main_phase[PhaseWidth-1:8];
      inc_int = cfg_increment[PhaseWidth-1:8];
      thr     = (16'(PwmBase) + 16'(cfg_shape)) << 8;

      // detuned voices move only in the quad modes, after the main phase
      if (cfg_mode == MODE_QUAD_SAW || cfg_mode == MODE_QUAD_PWM) begin
         prod   = 23'(inc_int) * 23'(cfg_shape);
         spread = 16'(prod >> SpreadShift) + 16'd1;
         step   = inc_int;
         for (i = 0; i < DetunedVoices; i++) begin
            step           = step + spread;
            voice_phase[i] = voice_phase[i] + step;
         end
      end

      case (cfg_mode)
         MODE_MANGLE_SAW: begin
            acc = ((p[15:8] ^ {cfg_shape, 1'b0}) & ~{1'b0, cfg_shape})
                  + {2'b00, cfg_shape[6:1]};
         end
         MODE_FOLD_TRI: begin
            t = p[14:7];
            v = p[15] ? t : ~t;
            if (v < {1'b0, cfg_shape}) v = {cfg_shape, 1'b0} - v;
            acc = v;
         end
         MODE_HARD_PWM: begin
            acc = (9'(p[15:8]) < 9'(PwmBase) + 9'(cfg_shape)) ? '0 : SampleFull;
         end
         MODE_QUAD_SAW: begin
            acc = 8'(p >> SawShift);
            for (i = 0; i < DetunedVoices; i++) acc += 8'(voice_phase[i] >> SawShift);
         end
         MODE_QUAD_PWM: begin
            acc = (p < thr) ? '0 : PwmStep;
            for (i = 0; i < DetunedVoices; i++)
               acc += (voice_phase[i] < thr) ? '0 : PwmStep;
         end
         default: begin
            acc = SampleMid;
         end
      endcase

      r.sample = acc;
      return r;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= ReportLimit) $display("%0t: %s", $realtime, msg);
   endtask

   // monitor: both handshakes sampled at the rising edge, request side first
   always @(posedge clock) begin
      osc_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_samples.push_back(predict_response(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_error($sformatf("response with none pending: tdata %h", rsp_tdata));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[7:0] !== want.sample || rsp_tdata[8] !== want.sync_out)
                  report_error($sformatf(
                     "sample mismatch: expected sample %h sync %b, got sample %h sync %b",
                     want.sample, want.sync_out, rsp_tdata[7:0], rsp_tdata[8]));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("FAIL multimode_phase_oscillator");
         $finish;
      end
   end

   // receiver: the stall style is redrawn whenever stall_left runs out, plus the long hold-off
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HoldCycles;
         hold_request = 1'b0;
      end
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(16, 96);
      end
      stall_left--;
      stall_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         case (stall_style)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = ($urandom_range(0, 3) != 0);
            2:       rsp_tready = 1'($urandom_range(0, 1));
            default: rsp_tready = (stall_tick % 3 == 0);
         endcase
      end
   end

   // offer one request, in bursts with random gaps; returns on the falling edge
   // after acceptance with valid still high so the next request can follow
   task automatic send_request(input logic sync_in);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = {7'b0, sync_in};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   // drain everything, then write one register while the block is idle
   task automatic csr_write(input csr_index_type index, input logic [CsrDataWidth-1:0] value);
      req_tvalid = 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      case (index)
         CSR_WAVEFORM_MODE:   cfg_mode      = value[ModeWidth-1:0];
         CSR_SHAPE_AMOUNT:    cfg_shape     = value[ShapeWidth-1:0];
         CSR_PHASE_INCREMENT: cfg_increment = value[PhaseWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_voice(input logic [ModeWidth-1:0] mode, input logic [ShapeWidth-1:0] shape,
                            input logic [PhaseWidth-1:0] increment);
      csr_write(CSR_WAVEFORM_MODE, CsrDataWidth'(mode));
      csr_write(CSR_SHAPE_AMOUNT, CsrDataWidth'(shape));
      csr_write(CSR_PHASE_INCREMENT, increment);
   endtask

   // every mode, shape and increment extremes, sync, carry and the spare codes
   task automatic test_directed();
      // reset configuration: mangle saw, no shape, zero increment
      send_request(1'b0);
      send_request(1'b1);
      // full-scale increment: the second step carries, sync restarts the phase
      set_voice(MODE_MANGLE_SAW, ShapeMax, IncrementMax);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      // fold with the widest fold level
      set_voice(MODE_FOLD_TRI, ShapeMax, 24'h400000);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      // pwm at the narrowest width, edge of the compare
      set_voice(MODE_HARD_PWM, '0, 24'h7F8000);
      send_request(1'b0);
      send_request(1'b0);
      // quad saw at full detune; sync leaves the detuned voices running
      set_voice(MODE_QUAD_SAW, ShapeMax, 24'hFFFF00);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      // quad pwm, both width extremes
      set_voice(MODE_QUAD_PWM, '0, 24'h123456);
      send_request(1'b0);
      send_request(1'b0);
      csr_write(CSR_SHAPE_AMOUNT, CsrDataWidth'(ShapeMax));
      send_request(1'b0);
      send_request(1'b1);
      // spare mode codes: midscale out, main phase still runs, voices hold
      set_voice(ModeSpareLow, 7'h2A, IncrementMax);
      send_request(1'b0);
      send_request(1'b0);
      csr_write(CSR_WAVEFORM_MODE, CsrDataWidth'(ModeSpareMid));
      send_request(1'b1);
      csr_write(CSR_WAVEFORM_MODE, CsrDataWidth'(ModeSpareHigh));
      send_request(1'b0);
      // back to a quad mode to show the voices were held
      csr_write(CSR_WAVEFORM_MODE, CsrDataWidth'(MODE_QUAD_SAW));
      send_request(1'b0);
   endtask

   // random settings, each followed by a run of samples with occasional sync
   task automatic test_random();
      int                    target;
      int                    run;
      logic [ModeWidth-1:0]  mode;
      logic [ShapeWidth-1:0] shape;
      logic [PhaseWidth-1:0] increment;
      target = items_sent + RandomItems;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0)
            mode = ModeWidth'($urandom_range(ModeSpareLow, ModeSpareHigh));
         else mode = ModeWidth'($urandom_range(MODE_MANGLE_SAW, MODE_QUAD_PWM));
         case ($urandom_range(0, 4))
            0:       shape = '0;
            1:       shape = ShapeMax;
            default: shape = ShapeWidth'($urandom_range(0, ShapeMax));
         endcase
         case ($urandom_range(0, 5))
            0:       increment = '0;
            1:       increment = IncrementMax;
            2, 3:    increment = PhaseWidth'($urandom_range(0, 24'h00FFFF));
            default: increment = PhaseWidth'($urandom_range(0, IncrementMax));
         endcase
         set_voice(mode, shape, increment);
         run = $urandom_range(20, 80);
         repeat (run) send_request($urandom_range(0, 15) == 0);
      end
   endtask

   // long receiver hold-off while requests keep coming: the block must stall
   task automatic test_backpressure();
      set_voice(MODE_QUAD_PWM, 7'h40, 24'h0A1B2C);
      hold_request = 1'b1;
      repeat (40) send_request($urandom_range(0, 7) == 0);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_random();
      test_backpressure();

      // wait for the last responses, then a short tail for strays
      req_tvalid = 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0 && expected_samples.size() == 0) begin
         $display("PASS multimode_phase_oscillator");
      end else begin
         $display("FAIL multimode_phase_oscillator");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/mpo_pkg.sv
design/multimode_phase_oscillator.sv
design/mpo_checker.sv
bench/testbench.sv
